FILE: rtl/fenw_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the fenwick frequency model
package fenw_pkg;

  localparam int NUM_SYMBOLS_DEF = 256;

  localparam logic [15:0] EXCL_FLAG  = 16'h8000;
  localparam logic [15:0] COUNT_MASK = 16'h7fff;

  // request codes
  localparam logic [2:0] REQ_QUERY  = 3'd0;
  localparam logic [2:0] REQ_FIND   = 3'd1;
  localparam logic [2:0] REQ_UPDATE = 3'd2;
  localparam logic [2:0] REQ_UPDX   = 3'd3;
  localparam logic [2:0] REQ_DEACT  = 3'd4;
  localparam logic [2:0] REQ_REACT  = 3'd5;
  localparam logic [2:0] REQ_RESET  = 3'd6;

  // register indexes on the config port
  localparam logic [1:0] REG_SYMBOL_COUNT = 2'd0;
  localparam logic [1:0] REG_MAX_TOTAL    = 2'd1;
  localparam logic [1:0] REG_INCREMENT    = 2'd2;

  typedef struct packed {
    logic [8:0]  symbol_count;
    logic [14:0] max_total;
    logic [13:0] increment;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  symbol;
    logic [15:0] cum_target;
  } in_item_t;

  typedef struct packed {
    logic [14:0] symbol_freq;
    logic [15:0] below_freq;
    logic [7:0]  found_symbol;
    logic [15:0] total_freq;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_QRY_START,
    DP_QRY_RD,
    DP_QRY_ACC,
    DP_FIND_INIT,
    DP_FIND_RD,
    DP_FIND_STEP,
    DP_FIND_END,
    DP_UPD,
    DP_UP_RD,
    DP_UP_WR,
    DP_SW_INIT,
    DP_SW_RD,
    DP_SW_WR,
    DP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   halve;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       in_range;
    logic       j_zero;
    logic       j_past_n;
    logic       mask_zero;
    logic       over_limit;
    logic       delta_zero;
    logic       sweep_last;
    logic       out_busy;
  } sts_t;

endpackage

FILE: rtl/fenw_ram.sv
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
module fenw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/fenw_ctrl.sv
`timescale 1ns / 1ps
// sequencer of the fenwick frequency model
module fenw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output fenw_pkg::cmd_t cmd_o,
  input  fenw_pkg::sts_t sts_i
);
  import fenw_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_QSTART = 5'd2;
  localparam logic [4:0] S_QRD    = 5'd3;
  localparam logic [4:0] S_QACC   = 5'd4;
  localparam logic [4:0] S_FINIT  = 5'd5;
  localparam logic [4:0] S_FRD    = 5'd6;
  localparam logic [4:0] S_FSTEP  = 5'd7;
  localparam logic [4:0] S_FEND   = 5'd8;
  localparam logic [4:0] S_UPD    = 5'd9;
  localparam logic [4:0] S_CHECK  = 5'd10;
  localparam logic [4:0] S_URD    = 5'd11;
  localparam logic [4:0] S_UWR    = 5'd12;
  localparam logic [4:0] S_SWINIT = 5'd13;
  localparam logic [4:0] S_SWRD   = 5'd14;
  localparam logic [4:0] S_SWWR   = 5'd15;
  localparam logic [4:0] S_FINISH = 5'd16;

  logic [4:0] state_q, state_d;
  logic       init_q, init_d;
  logic       halve_q, halve_d;

  always_comb begin
    state_d      = state_q;
    init_d       = init_q;
    halve_d      = halve_q;
    cmd_o.op     = DP_NOP;
    cmd_o.halve  = halve_q;
    in_stall_o   = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.req == REQ_FIND) begin
          state_d = S_FINIT;
        end else if (sts_i.req == REQ_RESET) begin
          halve_d = 1'b0;
          state_d = S_SWINIT;
        end else if (sts_i.req == REQ_QUERY && sts_i.in_range) begin
          state_d = S_QSTART;
        end else if (sts_i.req inside {REQ_UPDATE, REQ_UPDX, REQ_DEACT, REQ_REACT}
                     && sts_i.in_range) begin
          state_d = S_UPD;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_QSTART: begin
        cmd_o.op = DP_QRY_START;
        state_d  = S_QRD;
      end
      S_QRD: begin
        cmd_o.op = DP_QRY_RD;
        state_d  = sts_i.j_zero ? S_FINISH : S_QACC;
      end
      S_QACC: begin
        cmd_o.op = DP_QRY_ACC;
        state_d  = S_QRD;
      end
      S_FINIT: begin
        cmd_o.op = DP_FIND_INIT;
        state_d  = S_FRD;
      end
      S_FRD: begin
        cmd_o.op = DP_FIND_RD;
        state_d  = sts_i.mask_zero ? S_FEND : S_FSTEP;
      end
      S_FSTEP: begin
        cmd_o.op = DP_FIND_STEP;
        state_d  = S_FRD;
      end
      S_FEND: begin
        cmd_o.op = DP_FIND_END;
        state_d  = S_QSTART;
      end
      S_UPD: begin
        cmd_o.op = DP_UPD;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.over_limit) begin
          halve_d = 1'b1;
          state_d = S_SWINIT;
        end else if (sts_i.delta_zero) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_URD;
        end
      end
      S_URD: begin
        cmd_o.op = DP_UP_RD;
        state_d  = sts_i.j_past_n ? S_FINISH : S_UWR;
      end
      S_UWR: begin
        cmd_o.op = DP_UP_WR;
        state_d  = S_URD;
      end
      S_SWINIT: begin
        cmd_o.op = DP_SW_INIT;
        state_d  = S_SWRD;
      end
      S_SWRD: begin
        cmd_o.op = DP_SW_RD;
        state_d  = S_SWWR;
      end
      S_SWWR: begin
        cmd_o.op = DP_SW_WR;
        if (!sts_i.sweep_last) begin
          state_d = S_SWRD;
        end else if (init_q) begin
          init_d  = 1'b0;
          state_d = S_IDLE;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = DP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWINIT;
      init_q  <= 1'b1;
      halve_q <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      halve_q <= halve_d;
    end
  end

  a_accept_to_disp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == S_DISP)
    else $error("accepted item did not move to dispatch");

  a_init_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> in_stall_o)
    else $error("item accepted during power-up build");

  a_over_rescale : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && sts_i.over_limit) |=> (state_q == S_SWINIT && halve_q))
    else $error("total over limit without rescale");

endmodule

FILE: rtl/fenw_dp.sv
`timescale 1ns / 1ps
// datapath of the fenwick frequency model: count store, tree store and arithmetic
module fenw_dp #(
  parameter int NUM_SYMBOLS = fenw_pkg::NUM_SYMBOLS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fenw_pkg::cfg_t      cfg_i,
  input  fenw_pkg::in_item_t  in_item_i,
  input  fenw_pkg::cmd_t      cmd_i,
  output fenw_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fenw_pkg::out_item_t out_item_o
);
  import fenw_pkg::*;

  localparam int IW  = $clog2(NUM_SYMBOLS + 1);
  localparam int CW  = $clog2(NUM_SYMBOLS);
  localparam int JW  = IW + 1;
  localparam int NW  = (IW > 9) ? IW : 9;
  localparam int SIW = $clog2(IW + 1);

  logic [2:0]    req_q;
  logic [7:0]    sym_q;
  logic [15:0]   rem_q;
  logic [CW-1:0] qsym_q;
  logic [JW-1:0] j_q;
  logic [IW-1:0] mask_q;
  logic [IW-1:0] fsym_q;
  logic [15:0]   acc_q;
  logic [15:0]   delta_q;
  logic [15:0]   total_q;
  logic [15:0]   prefix_q;
  logic [15:0]   s_q [IW+1];
  logic          halve_q;
  logic          out_valid_q;
  out_item_t     out_q;

  // ram ports
  logic          cnt_we, cnt_re;
  logic [CW-1:0] cnt_waddr, cnt_raddr;
  logic [15:0]   cnt_wdata, cnt_rdata;
  logic          tr_we, tr_re;
  logic [IW-1:0] tr_waddr, tr_raddr;
  logic [15:0]   tr_wdata, tr_rdata;

  // effective config
  logic [NW-1:0] sc_w;
  logic [IW-1:0] n_eff;
  logic [15:0]   lim_a, lim_b, limit;
  logic [13:0]   inc;

  always_comb begin
    sc_w = NW'(cfg_i.symbol_count);
    if (sc_w < NW'(2)) begin
      sc_w = NW'(2);
    end else if (sc_w > NW'(NUM_SYMBOLS)) begin
      sc_w = NW'(NUM_SYMBOLS);
    end
    n_eff = IW'(sc_w);
    lim_a = 16'(cfg_i.max_total);
    lim_b = 16'({n_eff, 1'b0});
    limit = (lim_a < lim_b) ? lim_b : lim_a;
    inc   = (cfg_i.increment == '0) ? 14'd1 : cfg_i.increment;
  end

  logic          in_range;
  logic [IW-1:0] x_w;
  logic          x_le_n;
  logic [IW-1:0] found_w;
  logic [JW-1:0] lowbit;

  assign in_range = NW'(sym_q) < NW'(n_eff);
  assign x_w      = fsym_q | mask_q;
  assign x_le_n   = x_w <= n_eff;
  assign found_w  = (fsym_q >= n_eff) ? (n_eff - IW'(1)) : fsym_q;
  assign lowbit   = j_q & (~j_q + JW'(1));

  // highest power of two not above n
  logic [IW-1:0] top_mask;
  always_comb begin
    top_mask = '0;
    for (int b = 0; b < IW; b++) begin
      if (n_eff[b]) begin
        top_mask = IW'(1) << b;
      end
    end
  end

  // update arithmetic on the fetched count
  logic [14:0] cv;
  logic        cexcl;
  logic [15:0] nv_sum;
  logic [15:0] nv;
  logic [15:0] upd_word, upd_delta;

  always_comb begin
    cv     = cnt_rdata[14:0];
    cexcl  = cnt_rdata[15];
    nv_sum = 16'(cv) + 16'(inc);
    nv     = (nv_sum > COUNT_MASK) ? COUNT_MASK : nv_sum;
    case (req_q)
      REQ_UPDATE: begin
        upd_word  = (cnt_rdata & EXCL_FLAG) | nv;
        upd_delta = cexcl ? 16'd0 : (nv - 16'(cv));
      end
      REQ_UPDX: begin
        upd_word  = EXCL_FLAG | nv;
        upd_delta = cexcl ? 16'd0 : (16'd0 - 16'(cv));
      end
      REQ_DEACT: begin
        upd_word  = cnt_rdata | EXCL_FLAG;
        upd_delta = cexcl ? 16'd0 : (16'd0 - 16'(cv));
      end
      default: begin
        upd_word  = 16'(cv);
        upd_delta = cexcl ? 16'(cv) : 16'd0;
      end
    endcase
  end

  // sweep arithmetic: halve or set to one, then prefix-difference tree build
  logic           sw_jin;
  logic [15:0]    sw_half, sw_new;
  logic [15:0]    sw_a, prefix_d;
  logic [SIW-1:0] tz, sidx;

  always_comb begin
    sw_jin  = j_q <= JW'(n_eff);
    sw_half = ((16'(cnt_rdata[14:0]) + 16'd1) >> 1) | (cnt_rdata & EXCL_FLAG);
    if (halve_q) begin
      sw_new = sw_jin ? sw_half : cnt_rdata;
    end else begin
      sw_new = 16'd1;
    end
    sw_a     = (sw_jin && !sw_new[15]) ? (sw_new & COUNT_MASK) : 16'd0;
    prefix_d = prefix_q + sw_a;
    tz = '0;
    for (int b = JW - 1; b >= 0; b--) begin
      if (j_q[b]) begin
        tz = SIW'(b);
      end
    end
    sidx = tz + SIW'(1);
  end

  logic [14:0] q_freq;
  logic        q_valid;
  assign q_valid = (req_q == REQ_FIND) || (req_q == REQ_QUERY && in_range);
  assign q_freq  = (q_valid && !cnt_rdata[15]) ? cnt_rdata[14:0] : 15'd0;

  // ram port steering
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = qsym_q;
    cnt_wdata = upd_word;
    cnt_re    = 1'b0;
    cnt_raddr = CW'(in_item_i.symbol);
    tr_we     = 1'b0;
    tr_waddr  = IW'(j_q);
    tr_wdata  = tr_rdata + delta_q;
    tr_re     = 1'b0;
    tr_raddr  = IW'(j_q);
    case (cmd_i.op)
      DP_LOAD: begin
        cnt_re = 1'b1;
      end
      DP_QRY_RD: begin
        tr_re = (j_q != '0);
      end
      DP_FIND_RD: begin
        tr_re    = x_le_n;
        tr_raddr = x_w;
      end
      DP_FIND_END: begin
        cnt_re    = 1'b1;
        cnt_raddr = CW'(found_w);
      end
      DP_UPD: begin
        cnt_we = 1'b1;
      end
      DP_UP_RD: begin
        tr_re = (j_q <= JW'(n_eff));
      end
      DP_UP_WR: begin
        tr_we = 1'b1;
      end
      DP_SW_RD: begin
        cnt_re    = 1'b1;
        cnt_raddr = CW'(j_q - JW'(1));
      end
      DP_SW_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = CW'(j_q - JW'(1));
        cnt_wdata = sw_new;
        tr_we     = 1'b1;
        tr_wdata  = sw_jin ? (prefix_d - s_q[sidx]) : 16'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        req_q  <= in_item_i.req_type;
        sym_q  <= in_item_i.symbol;
        rem_q  <= in_item_i.cum_target;
        qsym_q <= CW'(in_item_i.symbol);
      end
      DP_QRY_START: begin
        j_q   <= JW'(qsym_q) + JW'(1);
        acc_q <= 16'd0;
      end
      DP_QRY_ACC: begin
        acc_q <= acc_q + tr_rdata;
        j_q   <= j_q & (j_q - JW'(1));
      end
      DP_FIND_INIT: begin
        mask_q <= top_mask;
        fsym_q <= '0;
      end
      DP_FIND_STEP: begin
        if (x_le_n && rem_q >= tr_rdata) begin
          rem_q  <= rem_q - tr_rdata;
          fsym_q <= x_w;
        end
        mask_q <= mask_q >> 1;
      end
      DP_FIND_END: begin
        qsym_q <= CW'(found_w);
      end
      DP_UPD: begin
        delta_q <= upd_delta;
        total_q <= total_q + upd_delta;
        j_q     <= JW'(qsym_q) + JW'(1);
      end
      DP_UP_WR: begin
        j_q <= j_q + lowbit;
      end
      DP_SW_INIT: begin
        j_q      <= JW'(1);
        prefix_q <= 16'd0;
        halve_q  <= cmd_i.halve;
        for (int b = 0; b <= IW; b++) begin
          s_q[b] <= 16'd0;
        end
      end
      DP_SW_WR: begin
        prefix_q <= prefix_d;
        j_q      <= j_q + JW'(1);
        for (int b = 0; b <= IW; b++) begin
          if (b <= int'(tz)) begin
            s_q[b] <= prefix_d;
          end
        end
        if (j_q == JW'(NUM_SYMBOLS)) begin
          total_q <= prefix_d;
        end
      end
      DP_RESULT: begin
        out_q.symbol_freq  <= q_freq;
        out_q.below_freq   <= q_valid ? (acc_q - 16'(q_freq)) : 16'd0;
        out_q.found_symbol <= (req_q == REQ_FIND) ? 8'(qsym_q) : 8'd0;
        out_q.total_freq   <= total_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == DP_RESULT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    sts_o.req        = req_q;
    sts_o.in_range   = in_range;
    sts_o.j_zero     = (j_q == '0);
    sts_o.j_past_n   = (j_q > JW'(n_eff));
    sts_o.mask_zero  = (mask_q == '0);
    sts_o.over_limit = (total_q > limit);
    sts_o.delta_zero = (delta_q == 16'd0);
    sts_o.sweep_last = (j_q == JW'(NUM_SYMBOLS));
    sts_o.out_busy   = out_valid_q && out_stall_i;
  end

  fenw_ram #(.WIDTH(16), .DEPTH(NUM_SYMBOLS)) u_counts (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  fenw_ram #(.WIDTH(16), .DEPTH(NUM_SYMBOLS + 1)) u_tree (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .waddr_i (tr_waddr),
    .wdata_i (tr_wdata),
    .re_i    (tr_re),
    .raddr_i (tr_raddr),
    .rdata_o (tr_rdata)
  );

  a_upd_in_tree : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_UP_WR) |-> (j_q != '0 && j_q <= JW'(n_eff)))
    else $error("tree update outside the symbol range");

  a_sweep_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_SW_WR) |-> (j_q != '0 && j_q <= JW'(NUM_SYMBOLS)))
    else $error("rebuild index out of range");

  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_RESULT) |-> !(out_valid_q && out_stall_i))
    else $error("result overwrote a waiting item");

endmodule

FILE: rtl/fenwick_frequency_model_core.sv
`timescale 1ns / 1ps
// adaptive symbol frequency model on a fenwick tree: top level with config registers
// one item at a time; a query walks the tree from symbol+1 down, a find walks it bit by bit
// update, exclude, deactivate, reactivate walk the tree path from the symbol up to n
// rescale and reset requests sweep every count
// cost is set by the tree walk through the one-read-port tree memory
// after reset the tree is built while no item is taken
module fenwick_frequency_model_core #(
  parameter int NUM_SYMBOLS = fenw_pkg::NUM_SYMBOLS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fenw_pkg::in_item_t  in_item_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fenw_pkg::out_item_t out_item_o,
  // config port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import fenw_pkg::*;

  cfg_t cfg_q, cfg_d;
  cmd_t cmd;
  sts_t sts;
  logic cfg_wr;

  // registers take writes only in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_SYMBOL_COUNT: cfg_d.symbol_count = pwdata[8:0];
        REG_MAX_TOTAL:    cfg_d.max_total    = pwdata[14:0];
        REG_INCREMENT:    cfg_d.increment    = pwdata[13:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.symbol_count <= 9'd256;
      cfg_q.max_total    <= 15'd16383;
      cfg_q.increment    <= 14'd24;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // readback, zero extended
  always_comb begin
    case (paddr[3:2])
      REG_SYMBOL_COUNT: prdata = 32'(cfg_q.symbol_count);
      REG_MAX_TOTAL:    prdata = 32'(cfg_q.max_total);
      REG_INCREMENT:    prdata = 32'(cfg_q.increment);
      default:          prdata = 32'd0;
    endcase
  end

  // sequencer: one item through at a time, result parked in the output register
  fenw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // count store, tree store, walk registers and result register
  fenw_dp #(.NUM_SYMBOLS(NUM_SYMBOLS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: tb/fenwick_frequency_model_core_test.sv
`timescale 1ns / 1ps
// testbench for the fenwick frequency model core: random and directed requests against a predictor
module fenwick_frequency_model_core_test;
  import fenw_pkg::*;

  localparam int NSYM = 256;
  // request code with no operation, not named in the package
  localparam logic [2:0] REQ_NOP = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  fenwick_frequency_model_core #(.NUM_SYMBOLS(NSYM)) i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk_i = ~clk_i;

  // mirror of the frequency model state and its registers
  logic [15:0] sym_counts [NSYM];
  logic [15:0] cum_tree [NSYM+1];
  logic [15:0] total_cnt;
  logic [8:0]  cfg_nsym;
  logic [14:0] cfg_limit;
  logic [13:0] cfg_inc;

  out_item_t expected_results [$];
  int mismatches = 0;
  int hold_cycles = 0;     // long receiver hold-off, counted by the stall process
  bit no_idle = 1'b0;      // stretch with no gaps on either side

  function automatic int used_symbols();
    int n = cfg_nsym;
    if (n < 2) n = 2;
    if (n > NSYM) n = NSYM;
    return n;
  endfunction

  function automatic int total_limit(int n);
    int m = cfg_limit;
    if (m < 2 * n) m = 2 * n;
    return m;
  endfunction

  function automatic int active_freq(int i);
    return sym_counts[i][15] ? 0 : int'(sym_counts[i][14:0]);
  endfunction

  function automatic void rebuild_tree(int n);
    int sum = 0;
    int p;
    for (int j = 0; j <= NSYM; j++) cum_tree[j] = '0;
    for (int j = 1; j <= n; j++) begin
      cum_tree[j] = 16'(active_freq(j - 1));
      sum += active_freq(j - 1);
    end
    for (int j = 1; j <= n; j++) begin
      p = j + (j & -j);
      if (p <= n) cum_tree[p] = cum_tree[p] + cum_tree[j];
    end
    total_cnt = 16'(sum);
  endfunction

  function automatic void halve_counts(int n);
    for (int i = 0; i < n; i++)
      sym_counts[i] = {sym_counts[i][15], 15'((int'(sym_counts[i][14:0]) + 1) >> 1)};
    rebuild_tree(n);
  endfunction

  function automatic void add_to_path(int sym, logic [15:0] delta, int n);
    total_cnt = total_cnt + delta;
    if (int'(total_cnt) > total_limit(n)) begin
      halve_counts(n);
      return;
    end
    for (int j = sym + 1; j <= n; j += (j & -j)) cum_tree[j] = cum_tree[j] + delta;
  endfunction

  function automatic void cum_below(int sym, output logic [14:0] freq,
                                    output logic [15:0] below);
    int j = sym + 1;
    int cul = 0;
    while (j != 0) begin
      cul += cum_tree[j];
      j &= j - 1;
    end
    freq = 15'(active_freq(sym));
    below = 16'(cul - active_freq(sym));
  endfunction

  function automatic int locate_symbol(int target, int n);
    int mask = 1;
    int sym = 0;
    int x;
    while ((mask << 1) <= n) mask <<= 1;
    while (mask != 0) begin
      x = sym | mask;
      if (x <= n && target >= cum_tree[x]) begin
        target -= cum_tree[x];
        sym = x;
      end
      mask >>= 1;
    end
    if (sym >= n) sym = n - 1;
    return sym;
  endfunction

  function automatic void uniform_counts();
    for (int i = 0; i < NSYM; i++) sym_counts[i] = 16'd1;
    rebuild_tree(used_symbols());
  endfunction

  // applies one request to the mirror and returns the result it must produce
  function automatic out_item_t model_request(in_item_t it);
    out_item_t r = '0;
    int n = used_symbols();
    int inc = (cfg_inc == 0) ? 1 : int'(cfg_inc);
    int sym = it.symbol;
    int v, nv, fs;
    logic excl;
    if (it.req_type == REQ_FIND) begin
      fs = locate_symbol(it.cum_target, n);
      r.found_symbol = 8'(fs);
      cum_below(fs, r.symbol_freq, r.below_freq);
    end else if (it.req_type == REQ_RESET) begin
      uniform_counts();
    end else if (it.req_type != REQ_NOP && sym < n) begin
      v = sym_counts[sym][14:0];
      excl = sym_counts[sym][15];
      nv = v + inc;
      if (nv > 32767) nv = 32767;
      case (it.req_type)
        REQ_QUERY: cum_below(sym, r.symbol_freq, r.below_freq);
        REQ_UPDATE: begin
          sym_counts[sym] = {excl, 15'(nv)};
          add_to_path(sym, excl ? 16'd0 : 16'(nv - v), n);
        end
        REQ_UPDX: begin
          sym_counts[sym] = {1'b1, 15'(nv)};
          add_to_path(sym, excl ? 16'd0 : 16'(-v), n);
        end
        REQ_DEACT: begin
          sym_counts[sym][15] = 1'b1;
          add_to_path(sym, excl ? 16'd0 : 16'(-v), n);
        end
        default: begin
          sym_counts[sym] = 16'(v);
          add_to_path(sym, excl ? 16'(v) : 16'd0, n);
        end
      endcase
    end
    r.total_freq = total_cnt;
    return r;
  endfunction

  // sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int p = $urandom_range(0, 99);
    if (no_idle || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(model_request(it));
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_req(logic [2:0] req, int sym, int target);
    in_item_t it;
    it.req_type = req;
    it.symbol = 8'(sym);
    it.cum_target = 16'(target);
    send_item(it);
  endtask

  // waits until every result is in, then lets a rescale sweep finish
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (2 * NSYM + 20) @(posedge clk_i);
  endtask

  // register write: setup cycle then access cycle, then back to idle
  task automatic write_reg(logic [1:0] idx, int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SYMBOL_COUNT: cfg_nsym = 9'(value);
      REG_MAX_TOTAL:    cfg_limit = 15'(value);
      default:          cfg_inc = 14'(value);
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(int nsym, int limit, int inc);
    wait_idle();
    write_reg(REG_SYMBOL_COUNT, nsym);
    write_reg(REG_MAX_TOTAL, limit);
    write_reg(REG_INCREMENT, inc);
  endtask

  // random request: mostly in-range updates, queries and finds, some noise
  task automatic send_random();
    int n = used_symbols();
    int p = $urandom_range(0, 99);
    int sym = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, n - 1);
    int target = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, total_cnt + 1);
    logic [2:0] req;
    if (p < 35) req = REQ_UPDATE;
    else if (p < 52) req = REQ_QUERY;
    else if (p < 70) req = REQ_FIND;
    else if (p < 78) req = REQ_UPDX;
    else if (p < 86) req = REQ_DEACT;
    else if (p < 95) req = REQ_REACT;
    else if (p < 97) req = REQ_RESET;
    else req = REQ_NOP;
    send_req(req, sym, target);
  endtask

  // extremes of the fields, every request code and the corner cases
  task automatic test_directed();
    send_req(REQ_QUERY, 0, 0);
    send_req(REQ_QUERY, 255, 65535);
    send_req(REQ_FIND, 0, 0);
    send_req(REQ_FIND, 0, 65535);        // target past total
    send_req(REQ_FIND, 255, 255);
    send_req(REQ_UPDATE, 7, 0);
    send_req(REQ_UPDX, 7, 0);
    send_req(REQ_UPDATE, 7, 0);          // update of an excluded symbol
    send_req(REQ_DEACT, 7, 0);           // deactivate of an excluded symbol
    send_req(REQ_QUERY, 7, 0);
    send_req(REQ_REACT, 7, 0);
    send_req(REQ_REACT, 7, 0);           // reactivate of an active symbol
    send_req(REQ_DEACT, 200, 0);
    send_req(REQ_NOP, 85, 43690);
    send_req(REQ_RESET, 170, 21845);
    // small alphabet, saturating count and halving
    configure(2, 32767, 16383);
    send_req(REQ_RESET, 0, 0);
    send_req(REQ_QUERY, 2, 0);           // symbol out of range
    send_req(REQ_UPDATE, 255, 0);
    send_req(REQ_UPDATE, 1, 0);
    send_req(REQ_UPDATE, 1, 0);
    send_req(REQ_UPDATE, 1, 0);
    send_req(REQ_FIND, 0, 65535);
    send_req(REQ_QUERY, 1, 0);
  endtask

  task automatic test_random_phase(int nsym, int limit, int inc, int count);
    configure(nsym, limit, inc);
    send_req(REQ_RESET, 0, 0);
    for (int i = 0; i < count; i++) send_random();
  endtask

  // receiver holds off while requests keep coming, a pause until drained, then a stretch with no gaps
  task automatic test_pressure();
    configure(256, 16383, 24);
    send_req(REQ_RESET, 0, 0);
    hold_cycles = 3000;
    for (int i = 0; i < 60; i++) send_random();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    no_idle = 1'b1;
    for (int i = 0; i < 80; i++) send_random();
    no_idle = 1'b0;
  endtask

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item_o);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_item_o !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", exp_r, out_item_o);
        end
      end
    end
  end

  // receiver stalls: bursts of random length, plus the long hold-off
  always @(posedge clk_i) begin
    int stall_left;
    int p;
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      p = $urandom_range(0, 99);
      if (no_idle || p < 80) out_stall_i <= 1'b0;
      else begin
        stall_left = (p < 97) ? $urandom_range(0, 2) : $urandom_range(15, 50);
        out_stall_i <= 1'b1;
      end
    end
  end

  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    cfg_nsym = 9'd256;
    cfg_limit = 15'd16383;
    cfg_inc = 14'd24;
    uniform_counts();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_phase(256, 16383, 24, 320);
    test_random_phase(2, 2, 1, 250);
    test_random_phase(17, 200, 16383, 250);
    test_random_phase(256, 32767, 1, 250);
    test_random_phase(100, 600, 300, 260);
    test_random_phase(64, 1000, 0, 200);
    test_random_phase(255, 3000, 8191, 200);
    test_pressure();
    wait_idle();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/fenw_pkg.sv
rtl/fenw_ram.sv
rtl/fenw_ctrl.sv
rtl/fenw_dp.sv
rtl/fenwick_frequency_model_core.sv
tb/fenwick_frequency_model_core_test.sv
